[hw/rtl/mke_pkg.sv]
`default_nettype none
package mke_pkg;

  // widest keying pattern (digit zero) in time units
  localparam int unsigned MaxUnits = 19;
  localparam int unsigned LenW     = $clog2(MaxUnits + 1);
  localparam int unsigned IdxW     = $clog2(MaxUnits);

  // one queued character: pattern right-aligned, first unit at bit len-1
  typedef struct packed {
    logic [MaxUnits-1:0] pat;
    logic [LenW-1:0]     len;
  } mke_item_t;

  typedef struct packed {
    logic      known;
    mke_item_t item;
  } mke_sym_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mke_q_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } mke_state_t;

  function automatic mke_sym_t mk_sym(input logic [LenW-1:0] len,
                                      input logic [MaxUnits-1:0] pat);
    mke_sym_t s;
    s.known    = 1'b1;
    s.item.pat = pat;
    s.item.len = len;
    return s;
  endfunction

  // character code to keying pattern
  function automatic mke_sym_t sym_lookup(input logic [7:0] code);
    mke_sym_t s;
    s = '0;
    unique case (code)
      8'h20: s = mk_sym(5'd7,  19'b0000000);             // word gap
      8'h5F: s = mk_sym(5'd3,  19'b000);                 // letter gap
      8'h41: s = mk_sym(5'd5,  19'b10111);
      8'h42: s = mk_sym(5'd9,  19'b111010101);
      8'h43: s = mk_sym(5'd11, 19'b11101011101);
      8'h44: s = mk_sym(5'd7,  19'b1110101);
      8'h45: s = mk_sym(5'd1,  19'b1);
      8'h46: s = mk_sym(5'd9,  19'b101011101);
      8'h47: s = mk_sym(5'd9,  19'b111011101);
      8'h48: s = mk_sym(5'd7,  19'b1010101);
      8'h49: s = mk_sym(5'd3,  19'b101);
      8'h4A: s = mk_sym(5'd13, 19'b1011101110111);
      8'h4B: s = mk_sym(5'd9,  19'b111010111);
      8'h4C: s = mk_sym(5'd9,  19'b101110101);
      8'h4D: s = mk_sym(5'd7,  19'b1110111);
      8'h4E: s = mk_sym(5'd5,  19'b11101);
      8'h4F: s = mk_sym(5'd11, 19'b11101110111);
      8'h50: s = mk_sym(5'd11, 19'b10111011101);
      8'h51: s = mk_sym(5'd13, 19'b1110111010111);
      8'h52: s = mk_sym(5'd7,  19'b1011101);
      8'h53: s = mk_sym(5'd5,  19'b10101);
      8'h54: s = mk_sym(5'd3,  19'b111);
      8'h55: s = mk_sym(5'd7,  19'b1010111);
      8'h56: s = mk_sym(5'd9,  19'b101010111);
      8'h57: s = mk_sym(5'd9,  19'b101110111);
      8'h58: s = mk_sym(5'd11, 19'b11101010111);
      8'h59: s = mk_sym(5'd13, 19'b1110101110111);
      8'h5A: s = mk_sym(5'd11, 19'b11101110101);
      8'h30: s = mk_sym(5'd19, 19'b1110111011101110111);
      8'h31: s = mk_sym(5'd17, 19'b10111011101110111);
      8'h32: s = mk_sym(5'd15, 19'b101011101110111);
      8'h33: s = mk_sym(5'd13, 19'b1010101110111);
      8'h34: s = mk_sym(5'd11, 19'b10101010111);
      8'h35: s = mk_sym(5'd9,  19'b101010101);
      8'h36: s = mk_sym(5'd11, 19'b11101010101);
      8'h37: s = mk_sym(5'd13, 19'b1110111010101);
      8'h38: s = mk_sym(5'd15, 19'b111011101110101);
      8'h39: s = mk_sym(5'd17, 19'b11101110111011101);
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mke_if.sv]
`default_nettype none
interface mke_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface mke_out_if;
  logic valid;
  logic ready;
  logic key_on;
  logic last_unit;

  modport source (output valid, output key_on, output last_unit, input ready);
  modport sink   (input valid, input key_on, input last_unit, output ready);
endinterface
`default_nettype wire

[hw/rtl/mke_front.sv]
`default_nettype none
module mke_front (
  mke_in_if.sink             in_ch,
  input  mke_pkg::mke_q_stat_t q_stat,
  output logic               push,
  output mke_pkg::mke_item_t push_item
);
  import mke_pkg::*;

  mke_sym_t sym;

  assign sym       = sym_lookup(in_ch.char_code);
  assign in_ch.ready = !q_stat.full;
  // unknown codes are taken and dropped
  assign push      = in_ch.valid && !q_stat.full && sym.known;
  assign push_item = sym.item;

endmodule
`default_nettype wire

[hw/rtl/mke_fifo.sv]
`default_nettype none
module mke_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mke_pkg::mke_item_t   push_item,
  input  logic                 pop,
  output mke_pkg::mke_item_t   pop_item,
  output mke_pkg::mke_q_stat_t q_stat
);
  import mke_pkg::*;

  // two entries
  mke_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mke_back.sv]
`default_nettype none
module mke_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mke_pkg::mke_q_stat_t q_stat,
  input  mke_pkg::mke_item_t   pop_item,
  output logic                 pop,
  mke_out_if.source            out_ch
);
  import mke_pkg::*;

  mke_state_t          state_r, state_nxt;
  logic [MaxUnits-1:0] pat_r, pat_nxt;
  logic [LenW-1:0]     cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                key_r, key_nxt;
  logic                last_r, last_nxt;
  logic                slot_free;
  logic                emit;
  logic [LenW-1:0]     idx;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign idx       = cnt_r - LenW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free && cnt_r == LenW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    unique case (state_r)
      ST_IDLE: pop  = !q_stat.empty;
      ST_EMIT: emit = slot_free;
      default: begin
        pop  = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    pat_nxt       = pat_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      pat_nxt = pop_item.pat;
      cnt_nxt = pop_item.len;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      key_nxt       = pat_r[idx[IdxW-1:0]];
      last_nxt      = (cnt_r == LenW'(1));
      cnt_nxt       = cnt_r - LenW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r  <= pat_nxt;
    key_r  <= key_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.key_on    = key_r;
  assign out_ch.last_unit = last_r;

endmodule
`default_nettype wire

[hw/rtl/morse_keying_encoder_core.sv]
`default_nettype none
// morse keying encoder
// in_ch carries one ascii character per request (space, underscore, A-Z, 0-9);
// out_ch answers with the keying pattern, one time unit per request:
// key_on is carrier on/off for that unit, last_unit marks the final unit
// dot is one on unit, dash three, elements split by one off unit;
// space gives seven off units, underscore three; other codes are
// accepted and dropped with no output
// front end looks the character up and pushes it into a two-entry queue;
// back end pulls one entry in its idle state, then plays one unit per cycle
// from its output register when the receiver never stalls; the first unit
// passes through the queue, the back end's pattern register and the
// output register on its way from the input request
// in_ch.ready drops only when the queue is full, so up to two characters
// can wait while the back end plays out; a stall on out_ch holds the
// current unit in the output register and the back end waits with it
// synchronous active-low reset empties the queue and the output register
module morse_keying_encoder_core (
  input  logic      clk,
  input  logic      rst_n,
  mke_in_if.sink    in_ch,
  mke_out_if.source out_ch
);
  import mke_pkg::*;

  mke_q_stat_t q_stat;
  mke_item_t   push_item;
  mke_item_t   pop_item;
  logic        push;
  logic        pop;

  // character lookup
  mke_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // decouples lookup from playback
  mke_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // unit-by-unit playback
  mke_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_item (pop_item),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

[verif/tb_morse_keying_encoder_core.sv]
`timescale 1ns / 100ps
module tb_morse_keying_encoder_core;
  import mke_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 40;

  localparam logic [7:0] CharSpace      = 8'h20;
  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam int unsigned WordGapUnits   = 7;
  localparam int unsigned LetterGapUnits = 3;

  // one keying time unit as the result channel carries it
  typedef struct packed {
    logic key_on;
    logic last_unit;
  } key_unit_t;

  logic clk;
  logic rst_n;

  mke_in_if  in_ch ();
  mke_out_if out_ch ();

  morse_keying_encoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // dot-dash spelling of every letter and digit
  string letter_marks [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };
  string digit_marks [10] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  key_unit_t   expected_units [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run guard: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("morse_keying_encoder_core regression: fail");
      $finish;
    end
  end

  // expand one character into its keying units and queue them
  function automatic void queue_keying_units(input logic [7:0] code);
    string       marks;
    logic        units [$];
    int unsigned gap_len;
    byte         mark;
    gap_len = 0;
    marks   = "";
    if (code == CharSpace) begin
      gap_len = WordGapUnits;
    end else if (code == CharUnderscore) begin
      gap_len = LetterGapUnits;
    end else if (code >= "A" && code <= "Z") begin
      marks = letter_marks[code - "A"];
    end else if (code >= "0" && code <= "9") begin
      marks = digit_marks[code - "0"];
    end else begin
      return;  // not encodable: no units at all
    end
    for (int i = 0; i < gap_len; i++) units.push_back(1'b0);
    for (int i = 0; i < marks.len(); i++) begin
      mark = marks[i];
      if (i > 0) units.push_back(1'b0);  // gap between elements
      units.push_back(1'b1);
      if (mark == "-") begin
        units.push_back(1'b1);
        units.push_back(1'b1);
      end
    end
    foreach (units[i]) begin
      expected_units.push_back('{key_on: units[i], last_unit: (i == units.size() - 1)});
    end
  endfunction

  // pick a character: mostly encodable ones, the rest any byte
  function automatic logic [7:0] pick_char();
    int unsigned sel;
    if ($urandom_range(99) >= 85) return 8'($urandom_range(255));
    sel = $urandom_range(37);
    if (sel < 26) return 8'("A" + sel);
    if (sel < 36) return 8'("0" + sel - 26);
    if (sel == 36) return CharSpace;
    return CharUnderscore;
  endfunction

  // one request on the input channel, with a random idle gap ahead of it
  task automatic send_char(input logic [7:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= code;
    do @(posedge clk); while (!in_ch.ready);
    queue_keying_units(code);
  endtask

  // hold the input idle until every queued unit has come back
  task automatic wait_units_drained();
    in_ch.valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic check_unit();
    key_unit_t want;
    if (expected_units.size() == 0) begin
      $error("unexpected unit: key_on %0b last_unit %0b", out_ch.key_on, out_ch.last_unit);
      error_count++;
    end else begin
      want = expected_units.pop_front();
      if (out_ch.key_on !== want.key_on) begin
        $error("key_on: expected %0b, actual %0b", want.key_on, out_ch.key_on);
        error_count++;
      end
      if (out_ch.last_unit !== want.last_unit) begin
        $error("last_unit: expected %0b, actual %0b", want.last_unit, out_ch.last_unit);
        error_count++;
      end
    end
  endtask

  // receiver: check each accepted unit, then stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_unit();
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // word gap and letter gap, back to back
  task automatic test_gap_chars();
    send_char(CharSpace);
    send_char(CharUnderscore);
    send_char(CharSpace);
  endtask

  // ends of both ranges, shortest and longest patterns
  task automatic test_table_edges();
    send_char("A");
    send_char("Z");
    send_char("0");
    send_char("9");
    send_char("E");
    send_char("T");
  endtask

  // codes around every accepted range, and the byte extremes
  task automatic test_unknown_codes();
    logic [7:0] codes [14] = '{
      8'h00, 8'hFF, 8'h1F, 8'h21, 8'h2F, 8'h3A, 8'h40,
      8'h5B, 8'h5E, 8'h60, 8'h61, 8'h7A, 8'h7F, 8'h80
    };
    foreach (codes[i]) send_char(codes[i]);
    send_char("K");  // a known one right after the dropped ones
  endtask

  // sender stops mid-stream until the block has played everything out
  task automatic test_pause_until_drained();
    repeat (5) send_char(pick_char());
    wait_units_drained();
    repeat (5) send_char(pick_char());
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    repeat (n_items) send_char(pick_char());
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    cycle_count     = 0;
    error_count     = 0;
    send_idle_pct   = 20;
    recv_idle_pct   = 53;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: sender idles lightly, receiver stalls often
    test_gap_chars();
    test_table_edges();
    test_unknown_codes();
    test_pause_until_drained();
    test_random_traffic(100);
    wait_units_drained();

    // phase two: the other way round
    send_idle_pct = 53;
    recv_idle_pct = 20;
    test_random_traffic(100);
    wait_units_drained();

    // phase three: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(100);
    wait_units_drained();

    if (error_count == 0) begin
      $display("morse_keying_encoder_core regression: pass");
    end else begin
      $display("morse_keying_encoder_core regression: fail");
    end
    $finish;
  end

endmodule
